### hdl/pis_pkg.sv
// package for the plic interface segment block
// shared widths, constants, case codes and sideband structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pis_pkg;

    localparam int FRAC_W        = 17;
    localparam int SUM_W         = 19;
    localparam int COORD_W       = 32;
    localparam int SIZE_W        = 31;
    localparam int LEVEL_W       = 4;
    localparam int SHIFT_W       = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int DEF_MAX_LEVEL = 15;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
    localparam logic [SIZE_W-1:0] ROOT_INIT = 31'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CASE_CORNER,
        CASE_BAND,
        CASE_FILL
    } t_case;

    // travels with the normal divider
    typedef struct packed {
        logic [FRAC_W-1:0]         c;
        logic                      invx;
        logic                      invz;
        logic                      x_big;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [LEVEL_W-1:0]        lvl;
    } t_side_div1;

    // travels with the square root
    typedef struct packed {
        t_case                     kase;
        logic [FRAC_W-1:0]         mm1;
        logic [FRAC_W-1:0]         e1;
        logic [FRAC_W-1:0]         e2;
        logic                      band_x;
        logic                      invx;
        logic                      invz;
        logic                      x_big;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [LEVEL_W-1:0]        lvl;
    } t_side_sqrt;

    // travels with the intercept divider
    typedef struct packed {
        t_case                     kase;
        logic [FRAC_W-1:0]         alpha;
        logic [FRAC_W-1:0]         e1;
        logic [FRAC_W-1:0]         e2;
        logic                      mm1_zero;
        logic                      band_x;
        logic                      invx;
        logic                      invz;
        logic                      x_big;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [LEVEL_W-1:0]        lvl;
    } t_side_div2;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_result;

endpackage

`default_nettype wire

### hdl/plic_interface_segment.sv
// Youngs interface segment for one 2D cell: stencil in, two endpoints out
// Channels: input word (stencil, origin, level) and output word (two endpoints),
// each with valid/ready; a word moves when valid and ready are both high.
// Configuration: i_cfg_we writes i_cfg_data into root width (index 0) or
// root height (index 1) at the clock edge; the user must write only while
// the pipeline is empty, and the block itself does not enforce it.
// Pipeline: front end, normal divider, case select, square root,
// intercept divider, endpoint and placement, output register.
// Throughput: one word per cycle while the pipeline is not stalled; the dividers
// and the square root are fully pipelined, one quotient or root bit per stage.
// Stall: when the receiver holds ready low, one word goes into a skid
// register and o_in_ready falls the next cycle; the whole pipeline then
// freezes, and nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and sets both root
// sizes to 1.0.
// Depends on pis_pkg, pis_pipe_div, pis_pipe_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module plic_interface_segment #(
    parameter int MAX_LEVEL = pis_pkg::DEF_MAX_LEVEL
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pis_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [pis_pkg::SIZE_W-1:0]            i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_sw,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_w,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_nw,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_s,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_center,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_n,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_se,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_e,
    input  wire logic [pis_pkg::FRAC_W-1:0]            i_frac_ne,
    input  wire logic signed [pis_pkg::COORD_W-1:0]    i_origin_x,
    input  wire logic signed [pis_pkg::COORD_W-1:0]    i_origin_y,
    input  wire logic [pis_pkg::LEVEL_W-1:0]           i_cell_level,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [pis_pkg::COORD_W-1:0]         o_start_x,
    output logic signed [pis_pkg::COORD_W-1:0]         o_start_y,
    output logic signed [pis_pkg::COORD_W-1:0]         o_end_x,
    output logic signed [pis_pkg::COORD_W-1:0]         o_end_y
);

    localparam int FW  = pis_pkg::FRAC_W;
    localparam int SW  = pis_pkg::SUM_W;
    localparam int CRW = pis_pkg::COORD_W;
    localparam int ZW  = pis_pkg::SIZE_W;
    localparam int LW  = pis_pkg::LEVEL_W;
    localparam int HW  = pis_pkg::SHIFT_W;
    localparam int PW  = ZW + FW;

    typedef struct packed {
        logic [SW-1:0]         sum_w;
        logic [SW-1:0]         sum_e;
        logic [SW-1:0]         sum_s;
        logic [SW-1:0]         sum_n;
        logic [FW-1:0]         c;
        logic signed [CRW-1:0] ox;
        logic signed [CRW-1:0] oy;
        logic [LW-1:0]         lvl;
    } t_st1;

    typedef struct packed {
        logic [SW-1:0]         ax;
        logic [SW-1:0]         az;
        logic                  invx;
        logic                  invz;
        logic [FW-1:0]         c;
        logic signed [CRW-1:0] ox;
        logic signed [CRW-1:0] oy;
        logic [LW-1:0]         lvl;
    } t_st2;

    typedef struct packed {
        pis_pkg::t_case        kase;
        logic [FW-1:0]         mm1;
        logic [FW-1:0]         cc;
        logic [FW-1:0]         c;
        logic                  invx;
        logic                  invz;
        logic                  x_big;
        logic signed [CRW-1:0] ox;
        logic signed [CRW-1:0] oy;
        logic [LW-1:0]         lvl;
    } t_st4;

    typedef struct packed {
        logic [FW-1:0]         x1;
        logic [FW-1:0]         z1;
        logic [FW-1:0]         x2;
        logic [FW-1:0]         z2;
        logic [ZW-1:0]         dx;
        logic [ZW-1:0]         dy;
        logic signed [CRW-1:0] ox;
        logic signed [CRW-1:0] oy;
    } t_st6;

    typedef struct packed {
        logic [CRW-1:0]        off_x1;
        logic [CRW-1:0]        off_z1;
        logic [CRW-1:0]        off_x2;
        logic [CRW-1:0]        off_z2;
        logic signed [CRW-1:0] ox;
        logic signed [CRW-1:0] oy;
    } t_st7;

    function automatic logic [FW-1:0] clamp_frac(input logic [FW-1:0] v);
        return (v > pis_pkg::FRAC_ONE) ? pis_pkg::FRAC_ONE : v;
    endfunction

    function automatic logic [SW-1:0] wsum(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                           input logic [FW-1:0] d);
        return SW'(a) + SW'({b, 1'b0}) + SW'(d);
    endfunction

    function automatic logic [CRW-1:0] place(input logic signed [CRW-1:0] org,
                                             input logic [CRW-1:0] off);
        logic signed [CRW+1:0] s;
        s = {{2{org[CRW-1]}}, org} + {2'b00, off};
        if (s > $signed({3'b000, {(CRW-1){1'b1}}})) begin
            return {1'b0, {(CRW-1){1'b1}}};
        end else if (s < $signed({3'b111, {(CRW-1){1'b0}}})) begin
            return {1'b1, {(CRW-1){1'b0}}};
        end
        return s[CRW-1:0];
    endfunction

    // configuration
    logic [ZW-1:0] r_root_w;
    logic [ZW-1:0] r_root_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_w <= pis_pkg::ROOT_INIT;
            r_root_h <= pis_pkg::ROOT_INIT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pis_pkg::CFG_ROOT_WIDTH) begin
                r_root_w <= i_cfg_data;
            end else if (i_cfg_index == pis_pkg::CFG_ROOT_HEIGHT) begin
                r_root_h <= i_cfg_data;
            end
        end
    end

    logic w_en;
    logic r_sk_vld;
    logic r_out_vld;

    assign w_en       = !r_sk_vld;
    assign o_in_ready = w_en;

    // stage 1: clamp and weighted column/row sums
    logic r_s1_vld;
    t_st1 r_s1;
    t_st1 n_s1;

    always_comb begin
        n_s1.sum_w = wsum(clamp_frac(i_frac_sw), clamp_frac(i_frac_w), clamp_frac(i_frac_nw));
        n_s1.sum_e = wsum(clamp_frac(i_frac_se), clamp_frac(i_frac_e), clamp_frac(i_frac_ne));
        n_s1.sum_s = wsum(clamp_frac(i_frac_sw), clamp_frac(i_frac_s), clamp_frac(i_frac_se));
        n_s1.sum_n = wsum(clamp_frac(i_frac_nw), clamp_frac(i_frac_n), clamp_frac(i_frac_ne));
        n_s1.c     = clamp_frac(i_frac_center);
        n_s1.ox    = i_origin_x;
        n_s1.oy    = i_origin_y;
        n_s1.lvl   = i_cell_level;
    end

    // stage 2: fold the gradient to non-negative
    logic r_s2_vld;
    t_st2 r_s2;
    t_st2 n_s2;

    always_comb begin
        n_s2.invx = (r_s1.sum_w < r_s1.sum_e);
        n_s2.invz = (r_s1.sum_s < r_s1.sum_n);
        n_s2.ax   = n_s2.invx ? (r_s1.sum_e - r_s1.sum_w) : (r_s1.sum_w - r_s1.sum_e);
        n_s2.az   = n_s2.invz ? (r_s1.sum_n - r_s1.sum_s) : (r_s1.sum_s - r_s1.sum_n);
        n_s2.c    = r_s1.c;
        n_s2.ox   = r_s1.ox;
        n_s2.oy   = r_s1.oy;
        n_s2.lvl  = r_s1.lvl;
    end

    // stage 3: smaller component over larger, the larger becomes one
    logic                  r_s3_vld;
    logic [SW+16-1:0]      r_d1_num;
    logic [SW-1:0]         r_d1_den;
    pis_pkg::t_side_div1   r_d1_side;
    logic                  w_x_big;

    assign w_x_big = (r_s2.ax >= r_s2.az);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_d1_num <= {(w_x_big ? r_s2.az : r_s2.ax) + SW'(1), 16'h0000};
            r_d1_den <= (w_x_big ? r_s2.ax : r_s2.az) + SW'(1);
            r_d1_side.c     <= r_s2.c;
            r_d1_side.invx  <= r_s2.invx;
            r_d1_side.invz  <= r_s2.invz;
            r_d1_side.x_big <= w_x_big;
            r_d1_side.ox    <= r_s2.ox;
            r_d1_side.oy    <= r_s2.oy;
            r_d1_side.lvl   <= r_s2.lvl;
        end
    end

    logic                w_q1_vld;
    logic [FW-1:0]       w_q1;
    pis_pkg::t_side_div1 w_q1_side;

    pis_pipe_div #(
        .NUM_W  (SW + 16),
        .DEN_W  (SW),
        .QUO_W  (FW),
        .SIDE_W ($bits(pis_pkg::t_side_div1))
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_num   (r_d1_num),
        .i_den   (r_d1_den),
        .i_side  (r_d1_side),
        .o_vld   (w_q1_vld),
        .o_quo   (w_q1),
        .o_side  (w_q1_side)
    );

    // stage 4: case select from the centre fraction
    logic          r_s4_vld;
    t_st4          r_s4;
    t_st4          n_s4;
    logic [FW-1:0] w_v1;
    logic [FW-1:0] w_v2;

    always_comb begin
        w_v1 = w_q1 >> 1;
        w_v2 = pis_pkg::FRAC_ONE - w_v1;
        if (w_q1_side.c < w_v1) begin
            n_s4.kase = pis_pkg::CASE_CORNER;
        end else if (w_q1_side.c < w_v2) begin
            n_s4.kase = pis_pkg::CASE_BAND;
        end else begin
            n_s4.kase = pis_pkg::CASE_FILL;
        end
        n_s4.cc    = (n_s4.kase == pis_pkg::CASE_CORNER) ? w_q1_side.c
                                                         : pis_pkg::FRAC_ONE - w_q1_side.c;
        n_s4.mm1   = w_q1;
        n_s4.c     = w_q1_side.c;
        n_s4.invx  = w_q1_side.invx;
        n_s4.invz  = w_q1_side.invz;
        n_s4.x_big = w_q1_side.x_big;
        n_s4.ox    = w_q1_side.ox;
        n_s4.oy    = w_q1_side.oy;
        n_s4.lvl   = w_q1_side.lvl;
    end

    // stage 5: radicand 2*cc*mm1 and the band intercepts
    logic                r_s5_vld;
    logic [2*FW-1:0]     r_rad;
    pis_pkg::t_side_sqrt r_sq_side;
    logic [2*FW-1:0]     w_prod;
    logic [FW+1:0]       w_a2;
    logic [FW+1:0]       w_two_m;
    logic [FW+1:0]       w_half;
    logic [FW+1:0]       w_rest;
    logic [FW-1:0]       w_e1;
    logic [FW-1:0]       w_e2;

    always_comb begin
        w_prod  = (2*FW)'(r_s4.cc) * (2*FW)'(r_s4.mm1);
        w_a2    = {1'b0, r_s4.c, 1'b0} + (FW+2)'(r_s4.mm1);
        w_two_m = {1'b0, r_s4.mm1, 1'b0};
        w_half  = w_a2 >> 1;
        w_rest  = (w_a2 > w_two_m) ? ((w_a2 - w_two_m) >> 1) : '0;
        w_e1    = (w_half > (FW+2)'(pis_pkg::FRAC_ONE)) ? pis_pkg::FRAC_ONE : w_half[FW-1:0];
        w_e2    = (w_rest > (FW+2)'(pis_pkg::FRAC_ONE)) ? pis_pkg::FRAC_ONE : w_rest[FW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= w_q1_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4 <= n_s4;
            r_rad <= {w_prod[2*FW-2:0], 1'b0};
            r_sq_side.kase   <= r_s4.kase;
            r_sq_side.mm1    <= r_s4.mm1;
            r_sq_side.e1     <= w_e1;
            r_sq_side.e2     <= w_e2;
            // band runs along x only when mx is strictly the larger
            r_sq_side.band_x <= r_s4.x_big && (r_s4.mm1 != pis_pkg::FRAC_ONE);
            r_sq_side.invx   <= r_s4.invx;
            r_sq_side.invz   <= r_s4.invz;
            r_sq_side.x_big  <= r_s4.x_big;
            r_sq_side.ox     <= r_s4.ox;
            r_sq_side.oy     <= r_s4.oy;
            r_sq_side.lvl    <= r_s4.lvl;
        end
    end

    logic                w_sq_vld;
    logic [FW-1:0]       w_alpha;
    pis_pkg::t_side_sqrt w_sq_side;

    pis_pipe_sqrt #(
        .ROOT_W (FW),
        .SIDE_W ($bits(pis_pkg::t_side_sqrt))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s5_vld),
        .i_rad   (r_rad),
        .i_side  (r_sq_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_alpha),
        .o_side  (w_sq_side)
    );

    // intercept on the smaller-normal axis: alpha / mm1
    pis_pkg::t_side_div2 w_d2_side;

    always_comb begin
        w_d2_side.kase     = w_sq_side.kase;
        w_d2_side.alpha    = w_alpha;
        w_d2_side.e1       = w_sq_side.e1;
        w_d2_side.e2       = w_sq_side.e2;
        w_d2_side.mm1_zero = (w_sq_side.mm1 == '0);
        w_d2_side.band_x   = w_sq_side.band_x;
        w_d2_side.invx     = w_sq_side.invx;
        w_d2_side.invz     = w_sq_side.invz;
        w_d2_side.x_big    = w_sq_side.x_big;
        w_d2_side.ox       = w_sq_side.ox;
        w_d2_side.oy       = w_sq_side.oy;
        w_d2_side.lvl      = w_sq_side.lvl;
    end

    logic                w_q2_vld;
    logic [FW-1:0]       w_q2;
    pis_pkg::t_side_div2 w_q2_side;

    pis_pipe_div #(
        .NUM_W  (FW + 16),
        .DEN_W  (FW),
        .QUO_W  (FW),
        .SIDE_W ($bits(pis_pkg::t_side_div2))
    ) u_div_icpt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_num   ({w_alpha, 16'h0000}),
        .i_den   (w_sq_side.mm1),
        .i_side  (w_d2_side),
        .o_vld   (w_q2_vld),
        .o_quo   (w_q2),
        .o_side  (w_q2_side)
    );

    // stage 6: unit endpoints, unfold, cell size
    logic          r_s6_vld;
    t_st6          r_s6;
    t_st6          n_s6;
    logic [FW-1:0] w_small;
    logic [FW-1:0] w_tx;
    logic [FW-1:0] w_tz;
    logic [HW-1:0] w_shamt;

    always_comb begin
        // a zero normal component only occurs with alpha zero
        w_small = w_q2_side.mm1_zero ? '0 : w_q2;
        w_tx    = w_q2_side.x_big ? w_q2_side.alpha : w_small;
        w_tz    = w_q2_side.x_big ? w_small : w_q2_side.alpha;
        n_s6.x1 = '0;
        n_s6.z1 = '0;
        n_s6.x2 = '0;
        n_s6.z2 = '0;
        unique case (w_q2_side.kase)
            pis_pkg::CASE_CORNER: begin
                n_s6.x1 = w_tx;
                n_s6.z2 = w_tz;
            end
            pis_pkg::CASE_BAND: begin
                if (w_q2_side.band_x) begin
                    n_s6.x1 = w_q2_side.e1;
                    n_s6.x2 = w_q2_side.e2;
                    n_s6.z2 = pis_pkg::FRAC_ONE;
                end else begin
                    n_s6.x2 = pis_pkg::FRAC_ONE;
                    n_s6.z1 = w_q2_side.e1;
                    n_s6.z2 = w_q2_side.e2;
                end
            end
            pis_pkg::CASE_FILL: begin
                n_s6.x1 = pis_pkg::FRAC_ONE - w_tx;
                n_s6.z1 = pis_pkg::FRAC_ONE;
                n_s6.x2 = pis_pkg::FRAC_ONE;
                n_s6.z2 = pis_pkg::FRAC_ONE - w_tz;
            end
            default: begin
                n_s6.x1 = '0;
            end
        endcase
        if (w_q2_side.invx) begin
            n_s6.x1 = pis_pkg::FRAC_ONE - n_s6.x1;
            n_s6.x2 = pis_pkg::FRAC_ONE - n_s6.x2;
        end
        if (w_q2_side.invz) begin
            n_s6.z1 = pis_pkg::FRAC_ONE - n_s6.z1;
            n_s6.z2 = pis_pkg::FRAC_ONE - n_s6.z2;
        end
        w_shamt = (HW'(w_q2_side.lvl) > HW'(MAX_LEVEL)) ? HW'(MAX_LEVEL)
                                                        : HW'(w_q2_side.lvl);
        n_s6.dx = r_root_w >> w_shamt;
        n_s6.dy = r_root_h >> w_shamt;
        n_s6.ox = w_q2_side.ox;
        n_s6.oy = w_q2_side.oy;
    end

    // stage 7: scale by the cell size
    logic          r_s7_vld;
    t_st7          r_s7;
    logic [PW-1:0] w_px1;
    logic [PW-1:0] w_pz1;
    logic [PW-1:0] w_px2;
    logic [PW-1:0] w_pz2;

    assign w_px1 = PW'(r_s6.dx) * PW'(r_s6.x1);
    assign w_pz1 = PW'(r_s6.dy) * PW'(r_s6.z1);
    assign w_px2 = PW'(r_s6.dx) * PW'(r_s6.x2);
    assign w_pz2 = PW'(r_s6.dy) * PW'(r_s6.z2);

    // stage 8: offset by the origin with saturation
    logic              r_tail_vld;
    pis_pkg::t_result  r_tail;
    pis_pkg::t_result  r_out;
    pis_pkg::t_result  r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld   <= 1'b0;
            r_s7_vld   <= 1'b0;
            r_tail_vld <= 1'b0;
        end else if (w_en) begin
            r_s6_vld   <= w_q2_vld;
            r_s7_vld   <= r_s6_vld;
            r_tail_vld <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6 <= n_s6;
            r_s7.off_x1 <= w_px1[PW-1:16];
            r_s7.off_z1 <= w_pz1[PW-1:16];
            r_s7.off_x2 <= w_px2[PW-1:16];
            r_s7.off_z2 <= w_pz2[PW-1:16];
            r_s7.ox     <= r_s6.ox;
            r_s7.oy     <= r_s6.oy;
            r_tail.start_x <= place(r_s7.ox, r_s7.off_x1);
            r_tail.start_y <= place(r_s7.oy, r_s7.off_z1);
            r_tail.end_x   <= place(r_s7.ox, r_s7.off_x2);
            r_tail.end_y   <= place(r_s7.oy, r_s7.off_z2);
        end
    end

    // output register with skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (w_en) begin
            if (!r_out_vld || i_out_ready) begin
                r_out_vld <= r_tail_vld;
            end else if (r_tail_vld) begin
                r_sk_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld <= 1'b1;
            r_sk_vld  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_vld || i_out_ready) begin
                r_out <= r_tail;
            end else begin
                r_sk <= r_tail;
            end
        end else if (i_out_ready) begin
            r_out <= r_sk;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_start_x   = r_out.start_x;
    assign o_start_y   = r_out.start_y;
    assign o_end_x     = r_out.end_x;
    assign o_end_y     = r_out.end_y;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_out_vld)
        else $error("skid word held while output register is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail_vld && w_en && r_out_vld && !i_out_ready) |=> r_sk_vld)
        else $error("word leaving the pipeline under stall was not captured");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_vld && i_out_ready) |=> (o_out_valid && !r_sk_vld))
        else $error("skid word not moved to output after ready");
`endif

endmodule

`default_nettype wire

### hdl/pis_pipe_div.sv
// pipelined restoring divider, one quotient bit per stage
// quotient must fit in QUO_W bits; sideband word rides along
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module pis_pipe_div #(
    parameter int NUM_W  = 35,
    parameter int DEN_W  = 19,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int CW = DEN_W + QUO_W;

    logic [CW-1:0]     r_rem  [1:QUO_W-1];
    logic [DEN_W-1:0]  r_den  [1:QUO_W-1];
    logic [QUO_W-1:0]  r_quo  [1:QUO_W];
    logic [SIDE_W-1:0] r_side [1:QUO_W];
    logic              r_vld  [1:QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic [CW-1:0]     w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [QUO_W-1:0]  w_quo;
        logic [SIDE_W-1:0] w_side;
        logic              w_vld;
        logic [CW-1:0]     w_dsh;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = CW'(i_num);
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k];
            assign w_den  = r_den[k];
            assign w_quo  = r_quo[k];
            assign w_side = r_side[k];
            assign w_vld  = r_vld[k];
        end

        assign w_dsh = CW'(w_den) << B;
        assign w_ge  = (w_rem >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1]  <= w_quo | (QUO_W'(w_ge) << B);
                r_side[k+1] <= w_side;
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? (w_rem - w_dsh) : w_rem;
                    r_den[k+1] <= w_den;
                end
            end
        end
    end

    assign o_vld  = r_vld[QUO_W];
    assign o_quo  = r_quo[QUO_W];
    assign o_side = r_side[QUO_W];

endmodule

`default_nettype wire

### hdl/pis_pipe_sqrt.sv
// pipelined integer square root (floor), one root bit per stage
// sideband word rides along with the radicand
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module pis_pipe_sqrt #(
    parameter int ROOT_W = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_vld,
    input  wire logic [2*ROOT_W-1:0] i_rad,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_vld,
    output logic [ROOT_W-1:0]        o_root,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int RW = 2 * ROOT_W;

    logic [RW-1:0]     r_rem  [1:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];
    logic [SIDE_W-1:0] r_side [1:ROOT_W];
    logic              r_vld  [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [RW-1:0]     w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SIDE_W-1:0] w_side;
        logic              w_vld;
        logic [RW-1:0]     w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_root = '0;
            assign w_side = i_side;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k];
            assign w_root = r_root[k];
            assign w_side = r_side[k];
            assign w_vld  = r_vld[k];
        end

        // (root + 2^b)^2 - root^2
        assign w_trial = (RW'(w_root) << (B + 1)) + (RW'(1) << (2 * B));
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= w_root | (ROOT_W'(w_ge) << B);
                r_side[k+1] <= w_side;
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? (w_rem - w_trial) : w_rem;
                end
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_root[ROOT_W];
    assign o_side = r_side[ROOT_W];

endmodule

`default_nettype wire

### sim/plic_interface_segment_test.sv
// self-checking testbench for plic_interface_segment (youngs interface segment)
// directed table then random stencils, checked against an in-bench predictor
// depends on pis_pkg and the plic_interface_segment rtl
`timescale 1ns / 1ps
`default_nettype none

module plic_interface_segment_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM     = 1850;
    localparam int DRAIN_CYCLES = 80;
    localparam longint UNIT     = 65536;
    localparam int FW           = pis_pkg::FRAC_W;
    localparam int CRW          = pis_pkg::COORD_W;
    localparam int LW           = pis_pkg::LEVEL_W;

    typedef struct {
        logic [FW-1:0]         f[9];
        logic signed [CRW-1:0] ox;
        logic signed [CRW-1:0] oy;
        logic [LW-1:0]         lvl;
    } t_cell;

    // directed row: stencil plus optional typed-in expectation
    typedef struct {
        t_cell            stim;
        bit               fixed;
        pis_pkg::t_result want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pis_pkg::CFG_IDX_W-1:0] i_cfg_index = pis_pkg::CFG_ROOT_WIDTH;
    logic [pis_pkg::SIZE_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [FW-1:0] i_frac[9];
    logic signed [CRW-1:0] i_origin_x = '0;
    logic signed [CRW-1:0] i_origin_y = '0;
    logic [LW-1:0] i_cell_level = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [CRW-1:0] o_start_x, o_start_y, o_end_x, o_end_y;

    initial foreach (i_frac[k]) i_frac[k] = '0;

    always #5 i_clk = ~i_clk;

    plic_interface_segment dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_frac_sw(i_frac[0]), .i_frac_w(i_frac[1]), .i_frac_nw(i_frac[2]),
        .i_frac_s(i_frac[3]), .i_frac_center(i_frac[4]), .i_frac_n(i_frac[5]),
        .i_frac_se(i_frac[6]), .i_frac_e(i_frac[7]), .i_frac_ne(i_frac[8]),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_cell_level(i_cell_level),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_start_x(o_start_x), .o_start_y(o_start_y),
        .o_end_x(o_end_x), .o_end_y(o_end_y)
    );

    longint           width_q = UNIT;
    longint           height_q = UNIT;
    pis_pkg::t_result pending_segments[$];
    int               errors = 0;
    int               seen = 0;
    longint           cycles = 0;
    int               send_idle = 19;
    int               recv_idle = 74;

    function automatic longint int_sqrt(longint v);
        longint r = 0;
        longint b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint quot_sat(longint num, longint den);
        longint q;
        if (num <= 0) return 0;
        if (den <= 0) return UNIT;
        q = num / den;
        return q > UNIT ? UNIT : q;
    endfunction

    function automatic longint unit_clamp(longint v);
        return v < 0 ? 0 : (v > UNIT ? UNIT : v);
    endfunction

    function automatic logic [31:0] place_pt(longint org, longint size, longint u);
        longint r = org + ((size * u) >>> 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic pis_pkg::t_result segment_of(t_cell cl);
        longint f[9];
        longint gx, gz, big, mx, mz, mm1, v1, a, a2, x1, z1, x2, z2, dx, dy;
        bit invx = 0, invz = 0;
        int sh;
        pis_pkg::t_result r;
        foreach (f[k]) f[k] = cl.f[k] > UNIT ? UNIT : longint'(cl.f[k]);
        gx = (f[0] + 2 * f[1] + f[2]) - (f[6] + 2 * f[7] + f[8]);
        gz = (f[0] + 2 * f[3] + f[6]) - (f[2] + 2 * f[5] + f[8]);
        if (gx < 0) begin gx = -gx; invx = 1; end
        if (gz < 0) begin gz = -gz; invz = 1; end
        gx += 1;
        gz += 1;
        big = gx > gz ? gx : gz;
        mx = gx * UNIT / big;
        mz = gz * UNIT / big;
        mm1 = mx < mz ? mx : mz;
        v1 = mm1 / 2;
        if (f[4] < v1) begin
            a = int_sqrt(2 * f[4] * mm1);
            x1 = quot_sat(a * UNIT, mx); z1 = 0;
            x2 = 0; z2 = quot_sat(a * UNIT, mz);
        end else if (f[4] < UNIT - v1) begin
            a2 = 2 * f[4] + mm1;
            if (mx > mz) begin
                x1 = quot_sat(a2 * (UNIT / 2), mx);
                x2 = quot_sat((a2 - 2 * mz) * (UNIT / 2), mx);
                z1 = 0; z2 = UNIT;
            end else begin
                x1 = 0; x2 = UNIT;
                z1 = quot_sat(a2 * (UNIT / 2), mz);
                z2 = quot_sat((a2 - 2 * mx) * (UNIT / 2), mz);
            end
        end else begin
            a = int_sqrt(2 * (UNIT - f[4]) * mm1);
            x1 = UNIT - quot_sat(a * UNIT, mx); z1 = UNIT;
            x2 = UNIT; z2 = UNIT - quot_sat(a * UNIT, mz);
        end
        x1 = unit_clamp(x1); z1 = unit_clamp(z1);
        x2 = unit_clamp(x2); z2 = unit_clamp(z2);
        if (invx) begin x1 = UNIT - x1; x2 = UNIT - x2; end
        if (invz) begin z1 = UNIT - z1; z2 = UNIT - z2; end
        sh = cl.lvl > pis_pkg::DEF_MAX_LEVEL ? pis_pkg::DEF_MAX_LEVEL : int'(cl.lvl);
        dx = width_q >> sh;
        dy = height_q >> sh;
        r.start_x = place_pt(cl.ox, dx, x1);
        r.start_y = place_pt(cl.oy, dy, z1);
        r.end_x = place_pt(cl.ox, dx, x2);
        r.end_y = place_pt(cl.oy, dy, z2);
        return r;
    endfunction

    function automatic logic [FW-1:0] rand_frac();
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return pis_pkg::FRAC_ONE;
            2: return FW'($urandom_range(65537, 131071));
            3: return FW'($urandom_range(0, 300));
            4: return FW'($urandom_range(65236, 65536));
            default: return FW'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell cl;
        int shape = $urandom_range(0, 3);
        logic [FW-1:0] lo = rand_frac(), hi = rand_frac();
        foreach (cl.f[k]) cl.f[k] = rand_frac();
        // shape 0 or 1: west/south side gets one random value, east/north another
        if (shape == 0) begin
            cl.f[0] = hi; cl.f[1] = hi; cl.f[2] = hi;
            cl.f[6] = lo; cl.f[7] = lo; cl.f[8] = lo;
        end else if (shape == 1) begin
            cl.f[0] = hi; cl.f[3] = hi; cl.f[6] = hi;
            cl.f[2] = lo; cl.f[5] = lo; cl.f[8] = lo;
        end
        cl.ox = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 2000000))
                - 1000000;
        cl.oy = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 2000000))
                - 1000000;
        cl.lvl = LW'($urandom_range(0, 15));
        return cl;
    endfunction

    function automatic t_cell flat_cell(logic [FW-1:0] v, logic [FW-1:0] ctr,
                                        logic signed [31:0] ox, logic signed [31:0] oy,
                                        logic [3:0] lvl);
        t_cell cl;
        foreach (cl.f[k]) cl.f[k] = v;
        cl.f[4] = ctr;
        cl.ox = ox; cl.oy = oy; cl.lvl = lvl;
        return cl;
    endfunction

    task automatic write_reg(logic [pis_pkg::CFG_IDX_W-1:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[pis_pkg::SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pis_pkg::CFG_ROOT_WIDTH) width_q = val[pis_pkg::SIZE_W-1:0];
        else height_q = val[pis_pkg::SIZE_W-1:0];
    endtask

    // valid stays up between back-to-back words; idle cycles drop it
    task automatic send_cell(t_cell cl, pis_pkg::t_result want);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        foreach (i_frac[k]) i_frac[k] <= cl.f[k];
        i_origin_x <= cl.ox;
        i_origin_y <= cl.oy;
        i_cell_level <= cl.lvl;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_segments.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_segments.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) i_out_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge i_clk) begin
        pis_pkg::t_result want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen++;
            if (pending_segments.size() == 0) begin
                $error("unexpected word start_x=%0d", o_start_x);
                errors++;
            end else begin
                want = pending_segments.pop_front();
                if (o_start_x !== want.start_x) begin
                    $error("start_x exp %0d got %0d", want.start_x, o_start_x); errors++;
                end
                if (o_start_y !== want.start_y) begin
                    $error("start_y exp %0d got %0d", want.start_y, o_start_y); errors++;
                end
                if (o_end_x !== want.end_x) begin
                    $error("end_x exp %0d got %0d", want.end_x, o_end_x); errors++;
                end
                if (o_end_y !== want.end_y) begin
                    $error("end_y exp %0d got %0d", want.end_y, o_end_y); errors++;
                end
            end
        end
    end

    t_row rows[$];

    initial begin
        t_cell cl;
        t_row rw;
        pis_pkg::t_result want;
        longint sizes[4] = '{UNIT, 1, 64'd2147483647, 64'd3 * UNIT};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // flat empty and flat full at reset sizes: readable at a glance
        rw.fixed = 1;
        rw.stim = flat_cell(0, 0, 0, 0, 0);
        rw.want = '{start_x: 0, start_y: 0, end_x: 0, end_y: 0};
        rows.push_back(rw);
        rw.stim = flat_cell(pis_pkg::FRAC_ONE, pis_pkg::FRAC_ONE, 0, 0, 0);
        rw.want = '{start_x: CRW'(UNIT), start_y: CRW'(UNIT), end_x: CRW'(UNIT),
                    end_y: CRW'(UNIT)};
        rows.push_back(rw);
        // over-one fractions, extreme origins, every level, every case
        rows.push_back('{flat_cell(17'h1ffff, 17'h1ffff, 32'h7fffffff, 32'h7fffffff, 0), 0, '0});
        rows.push_back('{flat_cell(0, 0, 32'h80000000, 32'h80000000, 15), 0, '0});
        rows.push_back('{flat_cell(0, 32768, 32'h7fff0000, -5, 1), 0, '0});
        for (int k = 0; k < 9; k++) begin
            cl = flat_cell(0, FW'(k * 8192), k * 1000, -k * 1000, 4'(k));
            cl.f[0] = pis_pkg::FRAC_ONE; cl.f[1] = pis_pkg::FRAC_ONE;
            cl.f[3] = pis_pkg::FRAC_ONE;
            rows.push_back('{cl, 0, '0});
            cl = flat_cell(pis_pkg::FRAC_ONE, FW'(k * 8192), -k, k, 4'(15 - k));
            cl.f[7] = 0; cl.f[8] = 0; cl.f[5] = 17'h1ffff;
            rows.push_back('{cl, 0, '0});
        end
        foreach (rows[k]) begin
            if (rows[k].fixed) want = rows[k].want;
            else want = segment_of(rows[k].stim);
            send_cell(rows[k].stim, want);
        end
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = ph == 0 ? 19 : (ph == 1 ? 74 : 0);
            recv_idle = ph == 0 ? 74 : (ph == 1 ? 19 : 0);
            write_reg(pis_pkg::CFG_ROOT_WIDTH, sizes[ph + 1]);
            write_reg(pis_pkg::CFG_ROOT_HEIGHT, sizes[(ph + 2) % 4]);
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                cl = rand_cell();
                send_cell(cl, segment_of(cl));
            end
            wait_drained();
        end

        $display("covered %0d segments over 4 size settings and 3 stall mixes", seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/pis_pkg.sv
hdl/pis_pipe_div.sv
hdl/pis_pipe_sqrt.sv
hdl/plic_interface_segment.sv
sim/plic_interface_segment_test.sv
